### hdl/rv64m_multiply_divide_unit_core_defines.svh
// ---------------------------------------------------------------------------
// RV64M multiply/divide unit assertion macros
// Shared concurrent assertion forms for the unit's RTL.
// ---------------------------------------------------------------------------
`ifndef RV64M_MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH
`define RV64M_MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH

// same-cycle implication
`define MDU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MDU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/mdu_pkg.sv
// ---------------------------------------------------------------------------
// RV64M multiply/divide unit package
// Operation codes, stage payload type and sizing constants.
// ---------------------------------------------------------------------------
package mdu_pkg;

   localparam int XLEN      = 64;
   localparam int HALF      = 32;
   localparam int DIV_STEPS = XLEN;

   typedef enum logic [3:0] {
      FUNC_MUL    = 4'd0,
      FUNC_MULH   = 4'd1,
      FUNC_MULHSU = 4'd2,
      FUNC_MULHU  = 4'd3,
      FUNC_DIV    = 4'd4,
      FUNC_DIVU   = 4'd5,
      FUNC_REM    = 4'd6,
      FUNC_REMU   = 4'd7,
      FUNC_MULW   = 4'd8,
      FUNC_DIVW   = 4'd9,
      FUNC_DIVUW  = 4'd10,
      FUNC_REMW   = 4'd11,
      FUNC_REMUW  = 4'd12
   } mdu_func_type;

   // x/y/z/w are reused per stage: operands, partial products, rem/quo/divisor
   typedef struct packed {
      logic            is_mul;
      logic            is_high;
      logic            is_word;
      logic            want_rem;
      logic            neg;
      logic            zero_res;
      logic [XLEN-1:0] x;
      logic [XLEN-1:0] y;
      logic [XLEN-1:0] z;
      logic [XLEN-1:0] w;
   } mdu_stage_type;

endpackage

### hdl/mdu_if.sv
// ---------------------------------------------------------------------------
// RV64M multiply/divide unit channels
// Request and response valid/ready interfaces.
// ---------------------------------------------------------------------------
interface mdu_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  func;
   logic [63:0] operand_a;
   logic [63:0] operand_b;

   modport source (output valid, output func, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input func, input operand_a, input operand_b,
                   output ready);
endinterface

interface mdu_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

### hdl/mdu_div_pipe.sv
// ---------------------------------------------------------------------------
// RV64M divide pipeline
// One restoring quotient bit per registered stage; multiplies pass through.
// ---------------------------------------------------------------------------
module mdu_div_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  mdu_pkg::mdu_stage_type in_stg,
   output logic                  out_vld,
   output mdu_pkg::mdu_stage_type out_stg
);
   import mdu_pkg::*;

   mdu_stage_type stg_ff [DIV_STEPS];
   mdu_stage_type stg_in [DIV_STEPS];
   logic          vld_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      mdu_stage_type     src;
      logic              src_vld;
      logic [XLEN:0]     shifted;
      logic [XLEN+1:0]   diff;
      logic              take;

      if (k == 0) begin : g_first
         assign src     = in_stg;
         assign src_vld = in_vld;
      end else begin : g_rest
         assign src     = stg_ff[k-1];
         assign src_vld = vld_ff[k-1];
      end

      always_comb begin
         shifted = {src.x, src.y[XLEN-1]};
         diff    = {1'b0, shifted} - {2'b00, src.z};
         take    = ~diff[XLEN+1];
         stg_in[k] = src;
         if (!src.is_mul && !src.zero_res) begin
            stg_in[k].x = take ? diff[XLEN-1:0] : shifted[XLEN-1:0];
            stg_in[k].y = {src.y[XLEN-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign out_vld = vld_ff[DIV_STEPS-1];
   assign out_stg = stg_ff[DIV_STEPS-1];

endmodule

### hdl/rv64m_multiply_divide_unit_core.sv
// ---------------------------------------------------------------------------
// RV64M multiply/divide unit core
// Fully pipelined MUL/MULH*/DIV*/REM* and word forms, one op per cycle.
// ---------------------------------------------------------------------------
// Channel  Dir  Payload                          Transfer
// req      in   func[3:0], operand_a, operand_b  valid & ready
// rsp      out  result[63:0]                     valid & ready
//
// Every op runs through input, decode, partial products, sum, carry,
// 64 divide steps (one quotient bit each), result fixup/output, in order.
// Throughput is one transfer per cycle; the pipeline advances as a whole
// whenever the output register is empty or being taken, so a stall freezes
// every stage. Synchronous reset clears only the stage valid bits.
// ---------------------------------------------------------------------------
module rv64m_multiply_divide_unit_core (
   input  logic      clock,
   input  logic      reset,
   mdu_req_if.sink   req,
   mdu_rsp_if.source rsp
);
   import mdu_pkg::*;

`include "rv64m_multiply_divide_unit_core_defines.svh"

   logic adv;

   // input register
   logic            s0_vld_ff;
   mdu_func_type    s0_func_ff;
   logic [XLEN-1:0] s0_a_ff, s0_b_ff;

   // decode, partial products, sum, carry stages
   logic          s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   mdu_stage_type s1_in, s2_in, s3_in, s4_in;
   mdu_stage_type s1_ff, s2_ff, s3_ff, s4_ff;

   // divide chain output
   logic          dv_vld;
   mdu_stage_type dv_stg;

   // output register
   logic            out_vld_ff;
   logic            out_zero_ff;
   logic [XLEN-1:0] out_res_ff;
   logic [XLEN-1:0] out_res_in;

   assign adv       = ~out_vld_ff | rsp.ready;
   assign req.ready = adv;

   // ---- decode: magnitudes, signs, special cases --------------------------
   always_comb begin
      logic            sa, sb, sgn, nn, dn, dz;
      logic [XLEN-1:0] mn, md;
      sa = 1'b0;
      sb = 1'b0;
      sgn = 1'b0;
      s1_in = '0;
      case (s0_func_ff)
         FUNC_MUL:    begin s1_in.is_mul = 1'b1; end
         FUNC_MULH:   begin s1_in.is_mul = 1'b1; s1_in.is_high = 1'b1;
                            sa = s0_a_ff[XLEN-1]; sb = s0_b_ff[XLEN-1]; end
         FUNC_MULHSU: begin s1_in.is_mul = 1'b1; s1_in.is_high = 1'b1;
                            sa = s0_a_ff[XLEN-1]; end
         FUNC_MULHU:  begin s1_in.is_mul = 1'b1; s1_in.is_high = 1'b1; end
         FUNC_MULW:   begin s1_in.is_mul = 1'b1; s1_in.is_word = 1'b1; end
         FUNC_DIV:    begin sgn = 1'b1; end
         FUNC_DIVU:   begin end
         FUNC_REM:    begin sgn = 1'b1; s1_in.want_rem = 1'b1; end
         FUNC_REMU:   begin s1_in.want_rem = 1'b1; end
         FUNC_DIVW:   begin sgn = 1'b1; s1_in.is_word = 1'b1; end
         FUNC_DIVUW:  begin s1_in.is_word = 1'b1; end
         FUNC_REMW:   begin sgn = 1'b1; s1_in.is_word = 1'b1;
                            s1_in.want_rem = 1'b1; end
         FUNC_REMUW:  begin s1_in.is_word = 1'b1; s1_in.want_rem = 1'b1; end
         default:     begin s1_in.zero_res = 1'b1; end
      endcase

      // word divide: 32-bit magnitudes, zero-extended
      nn = sgn & (s1_in.is_word ? s0_a_ff[HALF-1] : s0_a_ff[XLEN-1]);
      dn = sgn & (s1_in.is_word ? s0_b_ff[HALF-1] : s0_b_ff[XLEN-1]);
      dz = s1_in.is_word ? (s0_b_ff[HALF-1:0] == '0) : (s0_b_ff == '0);
      if (s1_in.is_word) begin
         mn = {{HALF{1'b0}}, nn ? -s0_a_ff[HALF-1:0] : s0_a_ff[HALF-1:0]};
         md = {{HALF{1'b0}}, dn ? -s0_b_ff[HALF-1:0] : s0_b_ff[HALF-1:0]};
      end else begin
         mn = nn ? -s0_a_ff : s0_a_ff;
         md = dn ? -s0_b_ff : s0_b_ff;
      end

      if (s1_in.is_mul) begin
         s1_in.neg = sa ^ sb;
         s1_in.x   = sa ? -s0_a_ff : s0_a_ff;
         s1_in.y   = sb ? -s0_b_ff : s0_b_ff;
      end else begin
         // divide by zero keeps the all-ones quotient unsigned
         s1_in.neg = s1_in.want_rem ? nn : ((nn ^ dn) & ~dz);
         s1_in.x   = '0;
         s1_in.y   = mn;
         s1_in.z   = md;
      end
   end

   // ---- four 32x32 partial products --------------------------------------
   always_comb begin
      s2_in = s1_ff;
      if (s1_ff.is_mul) begin
         s2_in.x = XLEN'(s1_ff.x[HALF-1:0]    * s1_ff.y[HALF-1:0]);
         s2_in.y = XLEN'(s1_ff.x[HALF-1:0]    * s1_ff.y[XLEN-1:HALF]);
         s2_in.z = XLEN'(s1_ff.x[XLEN-1:HALF] * s1_ff.y[HALF-1:0]);
         s2_in.w = XLEN'(s1_ff.x[XLEN-1:HALF] * s1_ff.y[XLEN-1:HALF]);
      end
   end

   // ---- column sums: low word done, high word waits for mid carry ---------
   always_comb begin
      logic [HALF+1:0] mid;
      mid = {2'b00, s2_ff.x[XLEN-1:HALF]} + {2'b00, s2_ff.y[HALF-1:0]}
          + {2'b00, s2_ff.z[HALF-1:0]};
      s3_in = s2_ff;
      if (s2_ff.is_mul) begin
         s3_in.x = {mid[HALF-1:0], s2_ff.x[HALF-1:0]};
         s3_in.y = s2_ff.w + {{HALF{1'b0}}, s2_ff.y[XLEN-1:HALF]}
                 + {{HALF{1'b0}}, s2_ff.z[XLEN-1:HALF]};
         s3_in.z = {{(XLEN-2){1'b0}}, mid[HALF+1:HALF]};
      end
   end

   always_comb begin
      s4_in = s3_ff;
      if (s3_ff.is_mul) begin
         s4_in.y = s3_ff.y + s3_ff.z;
      end
   end

   mdu_div_pipe u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (s4_vld_ff),
      .in_stg  (s4_ff),
      .out_vld (dv_vld),
      .out_stg (dv_stg)
   );

   // ---- sign fixup and selection ------------------------------------------
   always_comb begin
      logic [XLEN-1:0] lo, hi, v;
      lo = dv_stg.x;
      hi = dv_stg.y;
      if (dv_stg.neg) begin
         lo = -dv_stg.x;
         hi = ~dv_stg.y + XLEN'(dv_stg.x == '0);
      end
      if (dv_stg.is_mul) begin
         v = dv_stg.is_high ? hi : lo;
      end else begin
         v = dv_stg.want_rem ? dv_stg.x : dv_stg.y;
         if (dv_stg.neg) begin
            v = -v;
         end
      end
      if (dv_stg.is_word) begin
         v = {{HALF{v[HALF-1]}}, v[HALF-1:0]};
      end
      out_res_in = dv_stg.zero_res ? '0 : v;
   end

   // ---- valid bits -------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff  <= req.valid;
         s1_vld_ff  <= s0_vld_ff;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         out_vld_ff <= dv_vld;
      end
   end

   // ---- payload ----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_func_ff  <= mdu_func_type'(req.func);
         s0_a_ff     <= req.operand_a;
         s0_b_ff     <= req.operand_b;
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         s3_ff       <= s3_in;
         s4_ff       <= s4_in;
         out_res_ff  <= out_res_in;
         out_zero_ff <= dv_stg.zero_res;
      end
   end

   assign rsp.valid  = out_vld_ff;
   assign rsp.result = out_res_ff;

   `MDU_ASSERT_NEXT(a_accept_lands, clock, reset, req.valid && req.ready, s0_vld_ff, "accepted request not captured")
   `MDU_ASSERT_NEXT(a_stall_freezes, clock, reset, !adv, $stable(s1_vld_ff) && $stable(s4_vld_ff), "pipeline moved during stall")
   `MDU_ASSERT_NOW(a_unused_zero, clock, reset, rsp.valid && out_zero_ff, rsp.result == '0, "unused op gave nonzero result")

endmodule
